FILE: hw/rtl/ccrc_pkg.sv
// ccrc_pkg: shared types, codes and the crc-16-ccitt byte step for the
// chunked download checker; no dependencies, used by every rtl file

package ccrc_pkg;

  // default configuration and queue sizing
  localparam logic [15:0] CAPACITY_RESET = 16'd256;
  localparam int          QUEUE_DEPTH    = 2;

  // crc-16-ccitt polynomial, msb first, init zero
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // input function codes
  localparam logic [1:0] FUNC_HEADER = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  // classified operation carried through the queue
  localparam logic [1:0] OP_NOP    = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;
  localparam logic [1:0] OP_START  = 2'd3;

  // transfer phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_FAIL   = 2'd3;

  // error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_SEQ         = 4'd1;
  localparam logic [3:0] ERR_OFFSET      = 4'd2;
  localparam logic [3:0] ERR_TOO_LONG    = 4'd3;
  localparam logic [3:0] ERR_TOTALS      = 4'd4;
  localparam logic [3:0] ERR_EXCEEDS     = 4'd5;
  localparam logic [3:0] ERR_NO_PROGRESS = 4'd6;
  localparam logic [3:0] ERR_OFF_OVF     = 4'd7;
  localparam logic [3:0] ERR_CRC         = 4'd8;

  // one classified transaction as queued between front and back
  typedef struct packed {
    logic [1:0]  op;
    logic        too_long;
    logic [15:0] seq;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] xfer_total;
    logic [15:0] total_crc;
    logic [7:0]  data;
  } item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // one byte through the crc, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] byte_in);
    logic [15:0] c;
    c = crc_in ^ {byte_in, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/chunked_download_checker_crc16_core.sv
// chunked download checker with crc-16-ccitt, one result per transaction
// each transaction passes through a queue entry, then the result register;
// throughput: one transaction per cycle while out_stall stays low, set by
// the back end updating its transfer state on each pop
// reset: synchronous rst clears the queue, the transfer state and the result
// slot, and sets chunk capacity to 256
// depends on ccrc_pkg, ccrc_front, ccrc_queue, ccrc_back

module chunked_download_checker_crc16_core #(
  parameter int QUEUE_DEPTH = ccrc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] resp_seq,
  input  logic [15:0] resp_offset,
  input  logic [15:0] resp_length,
  input  logic [15:0] resp_total_length,
  input  logic [15:0] resp_total_crc,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  phase,
  output logic [3:0]  error_code,
  output logic [15:0] next_seq,
  output logic [15:0] next_offset,
  output logic [15:0] crc_value,
  output logic [15:0] bytes_written
);

  ccrc_pkg::item_t     push_item;
  ccrc_pkg::item_t     head_item;
  ccrc_pkg::q_status_t q_st;
  logic                push;
  logic                pop;

  // front end: accept and classify
  ccrc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .resp_seq          (resp_seq),
    .resp_offset       (resp_offset),
    .resp_length       (resp_length),
    .resp_total_length (resp_total_length),
    .resp_total_crc    (resp_total_crc),
    .data_byte         (data_byte),
    .q_st              (q_st),
    .push              (push),
    .push_item         (push_item)
  );

  // decoupling queue
  ccrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_st      (q_st)
  );

  // back end: checks, crc and result
  ccrc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_item     (head_item),
    .q_st          (q_st),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .phase         (phase),
    .error_code    (error_code),
    .next_seq      (next_seq),
    .next_offset   (next_offset),
    .crc_value     (crc_value),
    .bytes_written (bytes_written)
  );

  // result slot is empty right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a failed transfer always carries an error code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == ccrc_pkg::PH_FAIL |-> error_code != ccrc_pkg::ERR_NONE)
    else $error("failed phase without error code");

  // a transfer that has not failed has no error code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && phase != ccrc_pkg::PH_FAIL |-> error_code == ccrc_pkg::ERR_NONE)
    else $error("error code outside failed phase");

  // the back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) q_st.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

FILE: hw/rtl/ccrc_front.sv
// ccrc_front: accepts input transactions, holds the chunk capacity register
// and classifies each transaction for the queue; depends on ccrc_pkg

module ccrc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  logic [15:0]           resp_seq,
  input  logic [15:0]           resp_offset,
  input  logic [15:0]           resp_length,
  input  logic [15:0]           resp_total_length,
  input  logic [15:0]           resp_total_crc,
  input  logic [7:0]            data_byte,
  input  ccrc_pkg::q_status_t   q_st,
  output logic                  push,
  output ccrc_pkg::item_t       push_item
);

  logic [15:0] capacity;

  // chunk capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= ccrc_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // accept whenever the queue has room
  assign in_stall = q_st.full;
  assign push     = in_valid && !q_st.full;

  // classify the function code and precompute the capacity check
  always_comb begin
    case (func)
      ccrc_pkg::FUNC_HEADER: push_item.op = ccrc_pkg::OP_HEADER;
      ccrc_pkg::FUNC_DATA:   push_item.op = ccrc_pkg::OP_DATA;
      ccrc_pkg::FUNC_START:  push_item.op = ccrc_pkg::OP_START;
      default:               push_item.op = ccrc_pkg::OP_NOP;
    endcase
    push_item.too_long     = resp_length > capacity;
    push_item.seq          = resp_seq;
    push_item.offset       = resp_offset;
    push_item.length       = resp_length;
    push_item.xfer_total   = resp_total_length;
    push_item.total_crc    = resp_total_crc;
    push_item.data         = data_byte;
  end

endmodule

FILE: hw/rtl/ccrc_queue.sv
// ccrc_queue: short register queue between front and back
// depends on ccrc_pkg; DEPTH from 2 to 32

module ccrc_queue #(
  parameter int DEPTH = ccrc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ccrc_pkg::item_t     push_item,
  input  logic                pop,
  output ccrc_pkg::item_t     head_item,
  output ccrc_pkg::q_status_t q_st
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ccrc_pkg::item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_st.full  = (count == CNT_W'(DEPTH));
  assign q_st.empty = (count == '0);
  assign head_item  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/ccrc_back.sv
// ccrc_back: transfer state, header checks, crc update and result register
// depends on ccrc_pkg

module ccrc_back (
  input  logic                clk,
  input  logic                rst,
  input  ccrc_pkg::item_t     head_item,
  input  ccrc_pkg::q_status_t q_st,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          phase,
  output logic [3:0]          error_code,
  output logic [15:0]         next_seq,
  output logic [15:0]         next_offset,
  output logic [15:0]         crc_value,
  output logic [15:0]         bytes_written
);

  // transfer state
  logic [1:0]  phase_reg;
  logic [3:0]  error_reg;
  logic [15:0] seq_count;
  logic [15:0] offset_count;
  logic [15:0] written_count;
  logic [15:0] latched_total;
  logic [15:0] latched_crc;
  logic [15:0] running_crc;
  logic [15:0] chunk_len;
  logic [15:0] chunk_left;

  logic [1:0]  phase_next;
  logic [3:0]  error_next;
  logic [15:0] seq_next;
  logic [15:0] offset_next;
  logic [15:0] written_next;
  logic [15:0] total_next;
  logic [15:0] lcrc_next;
  logic [15:0] crc_next;
  logic [15:0] len_next;
  logic [15:0] left_next;

  logic        end_chunk;
  logic [15:0] end_len;
  logic [16:0] sum_written;
  logic [16:0] sum_offset;

  // a transaction leaves the queue when the result slot is free
  assign pop = !q_st.empty && (!out_valid || !out_stall);

  // next state for the head transaction
  always_comb begin
    phase_next   = phase_reg;
    error_next   = error_reg;
    seq_next     = seq_count;
    offset_next  = offset_count;
    written_next = written_count;
    total_next   = latched_total;
    lcrc_next    = latched_crc;
    crc_next     = running_crc;
    len_next     = chunk_len;
    left_next    = chunk_left;
    end_chunk    = 1'b0;
    end_len      = '0;
    sum_written  = '0;
    sum_offset   = '0;

    case (head_item.op)
      ccrc_pkg::OP_START: begin
        phase_next   = ccrc_pkg::PH_HEADER;
        error_next   = ccrc_pkg::ERR_NONE;
        seq_next     = '0;
        offset_next  = '0;
        written_next = '0;
        total_next   = '0;
        lcrc_next    = '0;
        crc_next     = '0;
        len_next     = '0;
        left_next    = '0;
      end
      ccrc_pkg::OP_HEADER: begin
        if (phase_reg == ccrc_pkg::PH_HEADER) begin
          if (head_item.seq != seq_count) begin
            phase_next = ccrc_pkg::PH_FAIL;
            error_next = ccrc_pkg::ERR_SEQ;
          end else if (head_item.offset != offset_count) begin
            phase_next = ccrc_pkg::PH_FAIL;
            error_next = ccrc_pkg::ERR_OFFSET;
          end else if (head_item.too_long) begin
            phase_next = ccrc_pkg::PH_FAIL;
            error_next = ccrc_pkg::ERR_TOO_LONG;
          end else if (seq_count != '0 &&
                       (head_item.xfer_total != latched_total ||
                        head_item.total_crc != latched_crc)) begin
            phase_next = ccrc_pkg::PH_FAIL;
            error_next = ccrc_pkg::ERR_TOTALS;
          end else begin
            // first chunk latches the totals
            if (seq_count == '0) begin
              total_next = head_item.xfer_total;
              lcrc_next  = head_item.total_crc;
            end
            sum_written = {1'b0, written_count} + {1'b0, head_item.length};
            if (sum_written > {1'b0, total_next}) begin
              phase_next = ccrc_pkg::PH_FAIL;
              error_next = ccrc_pkg::ERR_EXCEEDS;
            end else if (head_item.length != '0) begin
              len_next   = head_item.length;
              left_next  = head_item.length;
              phase_next = ccrc_pkg::PH_DATA;
            end else begin
              end_chunk = 1'b1;
              end_len   = '0;
            end
          end
        end
      end
      ccrc_pkg::OP_DATA: begin
        if (phase_reg == ccrc_pkg::PH_DATA) begin
          crc_next     = ccrc_pkg::crc_byte(running_crc, head_item.data);
          written_next = written_count + 16'd1;
          left_next    = chunk_left - 16'd1;
          if (left_next == '0) begin
            end_chunk = 1'b1;
            end_len   = chunk_len;
          end
        end
      end
      default: begin
      end
    endcase

    // chunk end: finish, fail, or advance offset and sequence
    if (end_chunk) begin
      sum_offset = {1'b0, offset_count} + {1'b0, end_len};
      if (written_next >= total_next) begin
        if (crc_next != lcrc_next) begin
          phase_next = ccrc_pkg::PH_FAIL;
          error_next = ccrc_pkg::ERR_CRC;
        end else begin
          phase_next = ccrc_pkg::PH_DONE;
        end
      end else if (end_len == '0) begin
        phase_next = ccrc_pkg::PH_FAIL;
        error_next = ccrc_pkg::ERR_NO_PROGRESS;
      end else if (sum_offset[16]) begin
        phase_next = ccrc_pkg::PH_FAIL;
        error_next = ccrc_pkg::ERR_OFF_OVF;
      end else begin
        offset_next = sum_offset[15:0];
        seq_next    = seq_count + 16'd1;
        phase_next  = ccrc_pkg::PH_HEADER;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= ccrc_pkg::PH_HEADER;
      error_reg     <= ccrc_pkg::ERR_NONE;
      seq_count     <= '0;
      offset_count  <= '0;
      written_count <= '0;
      latched_total <= '0;
      latched_crc   <= '0;
      running_crc   <= '0;
      chunk_len     <= '0;
      chunk_left    <= '0;
    end else if (pop) begin
      phase_reg     <= phase_next;
      error_reg     <= error_next;
      seq_count     <= seq_next;
      offset_count  <= offset_next;
      written_count <= written_next;
      latched_total <= total_next;
      latched_crc   <= lcrc_next;
      running_crc   <= crc_next;
      chunk_len     <= len_next;
      chunk_left    <= left_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      phase         <= phase_next;
      error_code    <= error_next;
      next_seq      <= seq_next;
      next_offset   <= offset_next;
      crc_value     <= crc_next;
      bytes_written <= written_next;
    end
  end

endmodule
